// ===== rtl/ratapx_pkg.sv =====
// shared constants for the rational approximation block
package ratapx_pkg;

  // width of the fixed-point input value
  localparam int unsigned VALUE_W = 32;

  // width of the saturated magnitude of the input
  localparam int unsigned MAG_W = VALUE_W - 1;

endpackage

// ===== rtl/ratapx_mulcmp.sv =====
// shared multiply unit and wide compare for one mediant test
module ratapx_mulcmp #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DEN_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic                                 recip_i,
  input  logic [ratapx_pkg::MAG_W-1:0]         mag_i,
  input  logic [DEN_BITS:0]                    mn_i,
  input  logic [DEN_BITS:0]                    md_i,
  output logic                                 gt_o
);
  import ratapx_pkg::*;

  localparam int unsigned MW = DEN_BITS + 1;
  localparam int unsigned PW = MAG_W + MW;
  localparam int unsigned SW = MW + FRAC_BITS;
  localparam int unsigned CW = (PW > SW) ? PW : SW;

  logic [PW-1:0] prod_q;
  logic [SW-1:0] shl_q;
  logic [MW-1:0] mul_b;
  logic [CW-1:0] prod_x;
  logic [CW-1:0] shl_x;

  // the magnitude is always one factor, the other is the mediant term
  assign mul_b = recip_i ? mn_i : md_i;

  // product and shifted term, registered for the compare cycle
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= PW'(mag_i) * PW'(mul_b);
      shl_q  <= recip_i ? {md_i, {FRAC_BITS{1'b0}}} : {mn_i, {FRAC_BITS{1'b0}}};
    end
  end

  // value above mediant: the mediant becomes the lower bound
  assign prod_x = CW'(prod_q);
  assign shl_x  = CW'(shl_q);
  assign gt_o   = recip_i ? (shl_x > prod_x) : (prod_x > shl_x);

endmodule

// ===== rtl/rational_approximation.sv =====
// rational approximation of a fixed-point value by a stern-brocot mediant walk
//
//  channel   dir  beat contents
//  s_axis    in   tdata: value (32, signed fixed point, FRAC_BITS fraction bits)
//  m_axis    out  tdata: numerator (DEN_BITS+1, signed), denominator (DEN_BITS)
//  cfg       in   cfg_data_i: max_denominator (DEN_BITS), no index
//
// each walk step is one pass through the shared multiplier (ST_MUL) and the
// wide compare with bound update (ST_CMP).
// s_axis_tready is high only while the walker is idle; a result waiting in the
// output register does not block the next input, only the next result load.
// reset clears the control state and sets max_denominator to 1000.
module rational_approximation #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DEN_BITS  = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // tdata: value
  input  logic [ratapx_pkg::VALUE_W-1:0]               s_axis_tdata,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // tdata: numerator, denominator, zero fill
  output logic [((2*DEN_BITS+1+7)/8)*8-1:0]            m_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  input  logic [DEN_BITS-1:0]                          cfg_data_i,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o
);
  import ratapx_pkg::*;

  localparam int unsigned MW     = DEN_BITS + 1;
  localparam int unsigned OUT_W  = 2 * DEN_BITS + 1;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam logic [DEN_BITS-1:0] MAXDEN_RST = DEN_BITS'(1000);
  localparam logic [VALUE_W:0]    ONE_Q      = (VALUE_W + 1)'(1) << FRAC_BITS;
  localparam logic [VALUE_W-1:0]  MOST_NEG   = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_FIN
  } state_e;

  state_e state_q;
  logic [DEN_BITS-1:0] max_q;
  logic [MAG_W-1:0]    mag_q;
  logic                neg_q;
  logic                recip_q;
  logic [MW-1:0]       ln_q, ld_q, un_q, ud_q, mn_q, md_q;
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q;

  logic                in_beat;
  logic [VALUE_W-1:0]  neg_raw;
  logic [MAG_W-1:0]    mag_w;
  logic                recip_w;
  logic                gt;
  logic [DEN_BITS-1:0] rn, rd, num, den;
  logic [DEN_BITS:0]   num_s;
  logic                lower_over;

  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // sign split and saturated magnitude
  assign neg_raw = -s_axis_tdata;
  always_comb begin
    if (s_axis_tdata == MOST_NEG) begin
      mag_w = {MAG_W{1'b1}};
    end else if (s_axis_tdata[VALUE_W-1]) begin
      mag_w = neg_raw[MAG_W-1:0];
    end else begin
      mag_w = s_axis_tdata[MAG_W-1:0];
    end
  end
  assign recip_w = {2'b00, mag_w} > ONE_Q;

  // shared multiply and compare unit
  ratapx_mulcmp #(
    .FRAC_BITS (FRAC_BITS),
    .DEN_BITS  (DEN_BITS)
  ) u_mulcmp (
    .clk_i   (clk_i),
    .load_i  (state_q == ST_MUL),
    .recip_i (recip_q),
    .mag_i   (mag_q),
    .mn_i    (mn_q),
    .md_i    (md_q),
    .gt_o    (gt)
  );

  // final choice of bound, swap for the reciprocal walk, sign
  assign lower_over = ld_q > MW'(max_q);
  assign rn         = lower_over ? un_q[DEN_BITS-1:0] : ln_q[DEN_BITS-1:0];
  assign rd         = lower_over ? ud_q[DEN_BITS-1:0] : ld_q[DEN_BITS-1:0];
  assign num        = recip_q ? rd : rn;
  assign den        = recip_q ? rn : rd;
  assign num_s      = neg_q ? -{1'b0, num} : {1'b0, num};

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAXDEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // walk sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // result valid: set by the final step, cleared by an accepted beat
      if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            state_q <= (max_q == '0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          // the replaced bound is the mediant, so it alone can pass the limit
          state_q <= (md_q <= MW'(max_q)) ? ST_MUL : ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // walk datapath: bounds, mediant and operand registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      mag_q   <= mag_w;
      neg_q   <= s_axis_tdata[VALUE_W-1];
      recip_q <= recip_w;
      ln_q    <= MW'(0);
      ld_q    <= MW'(1);
      un_q    <= MW'(1);
      ud_q    <= MW'(1);
      mn_q    <= MW'(1);
      md_q    <= MW'(2);
    end else if (state_q == ST_CMP) begin
      if (gt) begin
        ln_q <= mn_q;
        ld_q <= md_q;
        mn_q <= mn_q + un_q;
        md_q <= md_q + ud_q;
      end else begin
        un_q <= mn_q;
        ud_q <= md_q;
        mn_q <= ln_q + mn_q;
        md_q <= ld_q + md_q;
      end
    end
    if (state_q == ST_FIN && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {den, num_s};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'(out_data_q);

endmodule

// ===== rtl/ratapx_chk.sv =====
// port-level checks for the rational approximation block
module ratapx_chk #(
  parameter int unsigned DEN_BITS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [((2*DEN_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready
);
  import ratapx_pkg::*;

  logic [DEN_BITS:0]   num;
  logic [DEN_BITS-1:0] den;

  assign num = m_axis_tdata[DEN_BITS:0];
  assign den = m_axis_tdata[2*DEN_BITS:DEN_BITS+1];

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an accepted value keeps the walker busy for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a beat");

  // a new result is loaded only by a busy walker
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a walk");

  // a zero denominator only comes with a numerator of plus or minus one
  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (den == '0) |-> (num == (DEN_BITS+1)'(1)) || (num == '1))
    else $error("zero denominator with bad numerator");

endmodule

bind rational_approximation ratapx_chk #(
  .DEN_BITS (DEN_BITS)
) u_ratapx_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== sim/rational_approximation_tb.sv =====
// self-checking bench for the stern-brocot rational approximation block
`timescale 1ns / 100ps

module rational_approximation_tb;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DEN_BITS    = 16;
  localparam int unsigned VALUE_W     = ratapx_pkg::VALUE_W;
  localparam int unsigned OUT_W       = ((2*DEN_BITS+1+7)/8)*8;
  localparam int unsigned RES_W       = 2*DEN_BITS+1;
  localparam int unsigned N_PROBES    = 25;
  localparam int unsigned N_PHASES    = 5;
  localparam int unsigned PHASE_ITEMS = 20;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam bit [DEN_BITS:0] NEG_ONE = '1;
  localparam bit [63:0] ONE_FX        = 64'd1 << FRAC_BITS;
  localparam bit [63:0] MAG_SAT       = 64'h7FFF_FFFF;

  // result beat layout: numerator in the low bits, denominator above it
  typedef struct packed {
    bit [DEN_BITS-1:0] den;
    bit [DEN_BITS:0]   num;
  } ratio_t;

  typedef struct packed {
    bit [VALUE_W-1:0] value;
    ratio_t           res;
  } pending_t;

  typedef struct packed {
    bit [DEN_BITS-1:0] maxd;
    bit [VALUE_W-1:0]  value;
    bit                known;
    bit [DEN_BITS:0]   num;
    bit [DEN_BITS-1:0] den;
  } probe_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [VALUE_W-1:0]  s_data = '0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [DEN_BITS-1:0] cfg_data = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready_o;

  pending_t          pending_ratios [$];
  bit [DEN_BITS-1:0] cur_max = 16'd1000;
  bit                idle_en = 1'b1;
  bit                stall_sink = 1'b0;
  int unsigned       values_sent = 0;
  int unsigned       ratios_seen = 0;
  int unsigned       settings_used = 1;
  int unsigned       mismatches = 0;

  // directed probes: extremes, ties, saturation, reach limits, register extremes
  probe_row_t probe_rows [0:N_PROBES-1] = '{
    '{16'd1000,  32'h0000_0000, 1'b1, 17'd0,   16'd1},
    '{16'd1000,  32'h0000_0001, 1'b1, 17'd0,   16'd1},
    '{16'd1000,  32'hFFFF_FFFF, 1'b1, 17'd0,   16'd1},
    '{16'd1000,  32'h0001_0000, 1'b1, 17'd1,   16'd1},
    '{16'd1000,  32'hFFFF_0000, 1'b1, NEG_ONE, 16'd1},
    '{16'd1000,  32'h0000_8000, 1'b1, 17'd1,   16'd2},
    '{16'd1000,  32'hFFFF_8000, 1'b1, NEG_ONE, 16'd2},
    '{16'd1000,  32'h7FFF_FFFF, 1'b1, 17'd1,   16'd0},
    '{16'd1000,  32'h8000_0000, 1'b1, NEG_ONE, 16'd0},
    '{16'd1000,  32'h8000_0001, 1'b1, NEG_ONE, 16'd0},
    '{16'd1000,  32'h0001_0001, 1'b0, 17'd0,   16'd0},
    '{16'd1000,  32'h0001_8000, 1'b0, 17'd0,   16'd0},
    '{16'd1000,  32'h0003_243F, 1'b0, 17'd0,   16'd0},
    '{16'd1000,  32'hFFFC_DBC1, 1'b0, 17'd0,   16'd0},
    '{16'd1000,  32'h0000_5555, 1'b0, 17'd0,   16'd0},
    '{16'd1000,  32'h7FFF_0000, 1'b0, 17'd0,   16'd0},
    '{16'd1000,  32'h0000_FFFF, 1'b0, 17'd0,   16'd0},
    '{16'd1,     32'h0000_4000, 1'b1, 17'd0,   16'd1},
    '{16'd1,     32'h0000_C000, 1'b1, 17'd1,   16'd1},
    '{16'd1,     32'h0003_0000, 1'b1, 17'd1,   16'd0},
    '{16'd1,     32'hFFFF_4000, 1'b1, NEG_ONE, 16'd1},
    '{16'd1,     32'h7FFF_FFFF, 1'b1, 17'd1,   16'd0},
    '{16'd65535, 32'h0000_0000, 1'b1, 17'd0,   16'd1},
    '{16'd65535, 32'h0003_243F, 1'b0, 17'd0,   16'd0},
    '{16'd65535, 32'h7FFF_FFFF, 1'b0, 17'd0,   16'd0}
  };

  rational_approximation #(
    .FRAC_BITS(FRAC_BITS),
    .DEN_BITS (DEN_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_data),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .cfg_data_i   (cfg_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o)
  );

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mediant walk between 0/1 and 1/1, on the reciprocal above one
  function automatic ratio_t predict_ratio(input bit [VALUE_W-1:0] raw,
                                           input bit [DEN_BITS-1:0] maxd);
    bit        neg;
    bit        recip;
    bit [63:0] mag, lo_n, lo_d, hi_n, hi_d, med_n, med_d, lhs, rhs;
    bit [63:0] pick_n, pick_d, num, den;
    ratio_t    r;
    neg = raw[VALUE_W-1];
    mag = neg ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
    if (mag > MAG_SAT) mag = MAG_SAT;
    recip = mag > ONE_FX;
    lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
    while (lo_d <= maxd && hi_d <= maxd) begin
      med_n = lo_n + hi_n;
      med_d = lo_d + hi_d;
      if (recip) begin
        lhs = med_d << FRAC_BITS;
        rhs = med_n * mag;
      end else begin
        lhs = mag * med_d;
        rhs = med_n << FRAC_BITS;
      end
      // a tie moves the upper bound
      if (lhs > rhs) begin
        lo_n = med_n;
        lo_d = med_d;
      end else begin
        hi_n = med_n;
        hi_d = med_d;
      end
    end
    if (lo_d > maxd) begin
      pick_n = hi_n;
      pick_d = hi_d;
    end else begin
      pick_n = lo_n;
      pick_d = lo_d;
    end
    num = recip ? pick_d : pick_n;
    den = recip ? pick_n : pick_d;
    if (neg) num = 64'd0 - num;
    r.num = num[DEN_BITS:0];
    r.den = den[DEN_BITS-1:0];
    return r;
  endfunction

  // mix of full-range, small, near-one, simple-ratio and special values
  function automatic bit [VALUE_W-1:0] random_value();
    bit [VALUE_W-1:0] v;
    bit [VALUE_W-1:0] p, q;
    bit               neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      3: v = 32'h10000 + $urandom_range(0, 511) - 32'd256;
      4: begin
        p = $urandom_range(1, 20);
        q = $urandom_range(1, 20);
        v = (p << FRAC_BITS) / q;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h8000_0000;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h0001_0000;
          default: v = 32'h0000_0001;
        endcase
      end
    endcase
    if (neg && v != 32'h8000_0000) v = -v;
    return v;
  endfunction

  // offer one value beat, optionally after a gap, and queue its ratio
  task automatic offer_value(input bit [VALUE_W-1:0] v, input ratio_t want);
    int unsigned gap;
    pending_t    p;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    p.value = v;
    p.res   = want;
    pending_ratios.push_back(p);
    values_sent++;
  endtask

  // stop offering and wait for every queued ratio
  task automatic drain_ratios();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_ratios.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_den(input bit [DEN_BITS-1:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_max = v;
    settings_used++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // result side readiness: one long hold on request, else short random bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_sink) begin
        stall_sink = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest queued ratio
  ratio_t   got_ratio;
  pending_t want_ratio;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_ready) begin
      got_ratio = m_axis_tdata[RES_W-1:0];
      ratios_seen++;
      if (pending_ratios.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected ratio %0d/%0d", $time,
                 $signed(got_ratio.num), got_ratio.den);
      end else begin
        want_ratio = pending_ratios.pop_front();
        if (got_ratio.num !== want_ratio.res.num) begin
          mismatches++;
          $display("%0t: value %h numerator expected %0d got %0d", $time,
                   want_ratio.value, $signed(want_ratio.res.num),
                   $signed(got_ratio.num));
        end
        if (got_ratio.den !== want_ratio.res.den) begin
          mismatches++;
          $display("%0t: value %h denominator expected %0d got %0d", $time,
                   want_ratio.value, want_ratio.res.den, got_ratio.den);
        end
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // reset, directed probes, random phases, wrap-up
  initial begin
    int unsigned       i, ph, tail;
    bit [DEN_BITS-1:0] next_max;
    bit [VALUE_W-1:0]  v;
    ratio_t            want;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, typed results where obvious, predictor otherwise
    for (i = 0; i < N_PROBES; i++) begin
      if (probe_rows[i].maxd != cur_max) begin
        drain_ratios();
        write_max_den(probe_rows[i].maxd);
      end
      if (probe_rows[i].known) begin
        want.num = probe_rows[i].num;
        want.den = probe_rows[i].den;
      end else begin
        want = predict_ratio(probe_rows[i].value, cur_max);
      end
      offer_value(probe_rows[i].value, want);
    end

    // random phases, each with its own limit, no idling in the last
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: next_max = DEN_BITS'($urandom_range(2, 200));
        1: next_max = DEN_BITS'($urandom_range(1, 1000));
        2: next_max = DEN_BITS'($urandom_range(2, 40));
        3: next_max = DEN_BITS'($urandom_range(41, 255));
        default: next_max = DEN_BITS'($urandom_range(2, 300));
      endcase
      drain_ratios();
      if (ph == N_PHASES - 1) idle_en = 1'b0;
      write_max_den(next_max);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 3) stall_sink = 1'b1;
        if (ph == 1 && i == 10) drain_ratios();
        v = random_value();
        offer_value(v, predict_ratio(v, cur_max));
      end
    end

    drain_ratios();
    tail = 2 * cur_max + 16;
    if (tail > 4096) tail = 4096;
    repeat (tail) @(posedge clk_i);

    $display("tb: %0d values sent, %0d ratios compared", values_sent, ratios_seen);
    $display("tb: %0d max_denominator settings, from 1 up to 65535", settings_used);
    if (mismatches == 0 && pending_ratios.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ratapx_pkg.sv
rtl/ratapx_mulcmp.sv
rtl/rational_approximation.sv
rtl/ratapx_chk.sv
sim/rational_approximation_tb.sv
